// ===== rtl/lpht_pkg.sv =====
package lpht_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int VALUE_BITS_DEF  = 64;

    localparam int KEY_W   = 64;
    localparam int FIELD_W = 64;
    localparam int COUNT_W = 12;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [63:0] SEED_A   = 64'd12923598712359872066;
    localparam logic [63:0] SEED_MUL = 64'd7467732452331123588;
    localparam logic [63:0] SEED_0   = SEED_A;
    localparam logic [127:0] SEED_PROD = 128'(SEED_A) * 128'(SEED_MUL);
    localparam logic [63:0] SEED_1   = SEED_PROD[63:0];
    localparam logic [31:0] CRC_POLY = 32'h82F63B78;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODE = 1'b1;

    localparam logic [KEY_W-1:0] KEY_EMPTY = '0;
    localparam logic [KEY_W-1:0] KEY_TOMB  = 64'd1;

    typedef enum logic [1:0] {
        KIND_GET    = 2'd0,
        KIND_UPSERT = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_REMOVE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_INVALID  = 2'd3
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [KEY_W-1:0]   key;
        logic [FIELD_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [FIELD_W-1:0] found_value;
        logic [COUNT_W-1:0] live_count;
        logic [COUNT_W-1:0] tomb_count;
    } rsp_t;

endpackage

// ===== rtl/lpht_req_if.sv =====
interface lpht_req_if;
    logic valid;
    logic ready;
    lpht_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lpht_rsp_if.sv =====
interface lpht_rsp_if;
    logic valid;
    logic ready;
    lpht_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lpht_ram.sv =====
module lpht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/lpht_hash.sv =====
module lpht_hash #(
    parameter int NUM_SLOTS = 2048,
    parameter int AW = $clog2(NUM_SLOTS),
    parameter int SW = $clog2(NUM_SLOTS + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [lpht_pkg::KEY_W-1:0] key,
    input  logic                   mode,
    input  logic [SW-1:0]          slots,
    output logic                   done,
    output logic [AW-1:0]          slot
);
    import lpht_pkg::*;

    typedef enum logic [1:0] {H_IDLE, H_CRC, H_MOD} hstate_t;

    hstate_t     state_reg;
    logic        sel_reg;
    logic [2:0]  byte_reg;
    logic [5:0]  bit_reg;
    logic [31:0] crc_reg;
    logic [31:0] keylo_reg;
    logic [31:0] lo_reg;
    logic [63:0] hash_reg;
    logic [SW-1:0] rem_reg;
    logic        done_reg;

    logic [63:0] cur_seed;
    logic [31:0] crc_next;
    logic [SW:0] trial;
    logic [SW:0] rem_next;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        logic        b;
        r = c;
        for (int j = 0; j < 8; j++)
        begin
            b = r[0] ^ d[j];
            r = r >> 1;
            if (b)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    always_comb
    begin
        cur_seed = sel_reg ? SEED_1 : SEED_0;
        crc_next = crc_byte(crc_reg, cur_seed[byte_reg*8 +: 8]);
        trial = {rem_reg, hash_reg[63]};
        if (trial >= {1'b0, slots})
        begin
            rem_next = trial - {1'b0, slots};
        end
        else
        begin
            rem_next = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            sel_reg   <= 1'b0;
            byte_reg  <= '0;
            bit_reg   <= '0;
            crc_reg   <= '0;
            keylo_reg <= '0;
            lo_reg    <= '0;
            hash_reg  <= '0;
            rem_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                H_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        keylo_reg <= key[31:0];
                        crc_reg   <= key[31:0];
                        sel_reg   <= 1'b0;
                        byte_reg  <= '0;
                        bit_reg   <= '0;
                        rem_reg   <= '0;
                        if (mode)
                        begin
                            state_reg <= H_CRC;
                        end
                        else
                        begin
                            hash_reg  <= key;
                            state_reg <= H_MOD;
                        end
                    end
                end
                H_CRC:
                begin
                    byte_reg <= byte_reg + 3'd1;
                    if (byte_reg == 3'd7)
                    begin
                        if (!sel_reg)
                        begin
                            lo_reg  <= crc_next;
                            crc_reg <= keylo_reg;
                            sel_reg <= 1'b1;
                        end
                        else
                        begin
                            crc_reg   <= crc_next;
                            hash_reg  <= {crc_next, lo_reg};
                            state_reg <= H_MOD;
                        end
                    end
                    else
                    begin
                        crc_reg <= crc_next;
                    end
                end
                H_MOD:
                begin
                    rem_reg  <= rem_next[SW-1:0];
                    hash_reg <= {hash_reg[62:0], 1'b0};
                    bit_reg  <= bit_reg + 6'd1;
                    done_reg <= (bit_reg == 6'd63);
                    if (bit_reg == 6'd63)
                    begin
                        state_reg <= H_IDLE;
                    end
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign slot = rem_reg[AW-1:0];
endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// Channel  Direction  Payload
// req      sink       kind, key, value
// rsp      source     status, found_value, live_count, tomb_count
// cfg      write      cfg_we, cfg_index, cfg_data
//
// After reset all 2 * MAX_ENTRIES slots of the key memory are cleared before the first item.
// An item with key zero or one skips the hash and goes straight to the action state. A hashed
// key runs a bit-serial modulo (after a CRC in hash mode 1), then probes slot by slot, and a
// found get also reads its value. The probe loop uses the single key memory read port.
// A result waits in an output register; the next item may be taken meanwhile, but it
// stalls before its own result until the waiting one has gone.
module linear_probe_hash_table #(
    parameter int MAX_ENTRIES = lpht_pkg::MAX_ENTRIES_DEF,
    parameter int VALUE_BITS  = lpht_pkg::VALUE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    lpht_req_if.sink   req,
    lpht_rsp_if.source rsp,
    input  logic                           cfg_we,
    input  logic [lpht_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpht_pkg::CFG_W-1:0]     cfg_data
);
    import lpht_pkg::*;

    localparam int NUM_SLOTS = 2 * MAX_ENTRIES;
    localparam int AW = $clog2(NUM_SLOTS);
    localparam int SW = $clog2(NUM_SLOTS + 1);
    localparam int EW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_RD, S_CHK, S_ACT, S_VRD} state_t;

    state_t                 state_reg;
    logic [AW-1:0]          clr_reg;
    logic [EW-1:0]          entries_reg;
    logic                   mode_reg;
    kind_t                  kind_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [VALUE_BITS-1:0]  val_reg;
    logic [AW-1:0]          p_reg;
    logic [SW-1:0]          probe_reg;
    logic                   found_reg;
    logic                   empty_reg;
    logic                   tomb_reg;
    logic [AW-1:0]          hit_reg;
    logic [AW-1:0]          tomb_at_reg;
    logic [VALUE_BITS-1:0]  special_reg;
    logic [COUNT_W-1:0]     elem_reg;
    logic [COUNT_W-1:0]     tombc_reg;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_data_reg;

    logic [SW-1:0]          slots;
    logic                   accept;
    logic                   rsp_free;
    logic                   rsp_load;
    logic                   hash_start;
    logic                   hash_done;
    logic [AW-1:0]          hash_slot;
    logic [KEY_W-1:0]       key_rdata;
    logic [VALUE_BITS-1:0]  val_rdata;
    logic                   key_we;
    logic [AW-1:0]          key_waddr;
    logic [KEY_W-1:0]       key_wdata;
    logic                   val_we;
    logic [AW-1:0]          val_waddr;
    logic [31:0]            cfg_ent;
    logic [SW-1:0]          p_inc;

    status_t                act_status;
    logic [FIELD_W-1:0]     act_value;
    logic                   act_out;
    logic                   act_elem_inc;
    logic                   act_tomb_inc;
    logic                   act_spec_we;
    logic [VALUE_BITS-1:0]  act_spec;
    logic                   special_present;
    logic                   key_zero;
    logic                   key_one;

    assign slots    = SW'({entries_reg, 1'b0});
    assign rsp_free = !rsp_valid_reg || rsp.ready;
    assign rsp_load = rsp_free && (((state_reg == S_ACT) && act_out) || (state_reg == S_VRD));
    assign req.ready = (state_reg == S_IDLE);
    assign accept   = req.valid && req.ready;
    assign hash_start = accept && (req.data.key > KEY_TOMB);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;
    assign key_zero = (key_reg == KEY_EMPTY);
    assign key_one  = (key_reg == KEY_TOMB);
    assign special_present = (special_reg != '0);
    assign p_inc = SW'(p_reg) + SW'(1);

    lpht_hash #(.NUM_SLOTS(NUM_SLOTS)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (req.data.key),
        .mode  (mode_reg),
        .slots (slots),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    lpht_ram #(.WIDTH(KEY_W), .DEPTH(NUM_SLOTS)) u_keys (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (p_reg),
        .rdata (key_rdata)
    );

    lpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(NUM_SLOTS)) u_vals (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_reg),
        .raddr (hit_reg),
        .rdata (val_rdata)
    );

    always_comb
    begin
        cfg_ent = 32'(cfg_data);
        if (cfg_ent == 32'd0)
        begin
            cfg_ent = 32'd1;
        end
        if (cfg_ent > 32'(MAX_ENTRIES))
        begin
            cfg_ent = 32'(MAX_ENTRIES);
        end
    end

    always_comb
    begin
        act_status   = ST_NOTFOUND;
        act_value    = '0;
        act_out      = 1'b1;
        act_elem_inc = 1'b0;
        act_tomb_inc = 1'b0;
        act_spec_we  = 1'b0;
        act_spec     = '0;
        key_we       = 1'b0;
        key_waddr    = hit_reg;
        key_wdata    = key_reg;
        val_we       = 1'b0;
        val_waddr    = hit_reg;
        if (state_reg == S_CLEAR)
        begin
            key_we    = 1'b1;
            key_waddr = clr_reg;
            key_wdata = KEY_EMPTY;
        end
        else if (key_zero)
        begin
            act_status = ST_INVALID;
        end
        else if (key_one)
        begin
            case (kind_reg)
                KIND_GET:
                begin
                    act_value  = FIELD_W'(special_reg);
                    act_status = special_present ? ST_DONE : ST_NOTFOUND;
                end
                KIND_UPSERT:
                begin
                    act_spec_we = 1'b1;
                    act_spec    = val_reg;
                    act_status  = ST_DONE;
                end
                KIND_UPDATE:
                begin
                    act_spec_we = special_present;
                    act_spec    = val_reg;
                    act_status  = special_present ? ST_DONE : ST_NOTFOUND;
                end
                default:
                begin
                    act_spec_we = 1'b1;
                    act_status  = special_present ? ST_DONE : ST_NOTFOUND;
                end
            endcase
        end
        else
        begin
            case (kind_reg)
                KIND_GET:
                begin
                    act_out = !found_reg;
                end
                KIND_UPSERT:
                begin
                    if (found_reg)
                    begin
                        val_we     = 1'b1;
                        act_status = ST_DONE;
                    end
                    else if (tomb_reg || empty_reg)
                    begin
                        key_we       = 1'b1;
                        key_waddr    = tomb_reg ? tomb_at_reg : hit_reg;
                        val_we       = 1'b1;
                        val_waddr    = key_waddr;
                        act_elem_inc = 1'b1;
                        act_status   = ST_DONE;
                    end
                    else
                    begin
                        act_status = ST_FULL;
                    end
                end
                KIND_UPDATE:
                begin
                    val_we     = found_reg;
                    act_status = found_reg ? ST_DONE : ST_NOTFOUND;
                end
                default:
                begin
                    key_we       = found_reg;
                    key_wdata    = KEY_TOMB;
                    act_tomb_inc = found_reg;
                    act_status   = found_reg ? ST_DONE : ST_NOTFOUND;
                end
            endcase
        end
        if (state_reg != S_CLEAR && !(state_reg == S_ACT && rsp_free))
        begin
            key_we = 1'b0;
            val_we = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            entries_reg   <= EW'(MAX_ENTRIES);
            mode_reg      <= 1'b1;
            kind_reg      <= KIND_GET;
            key_reg       <= '0;
            val_reg       <= '0;
            p_reg         <= '0;
            probe_reg     <= '0;
            found_reg     <= 1'b0;
            empty_reg     <= 1'b0;
            tomb_reg      <= 1'b0;
            hit_reg       <= '0;
            tomb_at_reg   <= '0;
            special_reg   <= '0;
            elem_reg      <= '0;
            tombc_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ENTRIES)
                begin
                    entries_reg <= cfg_ent[EW-1:0];
                end
                else
                begin
                    mode_reg <= cfg_data[0];
                end
            end
            if (rsp_valid_reg && rsp.ready && !rsp_load)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(NUM_SLOTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg  <= req.data.kind;
                        key_reg   <= req.data.key;
                        val_reg   <= req.data.value[VALUE_BITS-1:0];
                        state_reg <= hash_start ? S_HASH : S_ACT;
                    end
                end
                S_HASH:
                begin
                    if (hash_done)
                    begin
                        p_reg     <= hash_slot;
                        probe_reg <= '0;
                        found_reg <= 1'b0;
                        empty_reg <= 1'b0;
                        tomb_reg  <= 1'b0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    hit_reg <= p_reg;
                    if (key_rdata == key_reg)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_ACT;
                    end
                    else if (key_rdata == KEY_EMPTY)
                    begin
                        empty_reg <= 1'b1;
                        state_reg <= S_ACT;
                    end
                    else
                    begin
                        if (key_rdata == KEY_TOMB && !tomb_reg)
                        begin
                            tomb_reg    <= 1'b1;
                            tomb_at_reg <= p_reg;
                        end
                        probe_reg <= probe_reg + SW'(1);
                        p_reg     <= (p_inc == slots) ? '0 : p_inc[AW-1:0];
                        state_reg <= (probe_reg == slots - SW'(1)) ? S_ACT : S_RD;
                    end
                end
                S_ACT:
                begin
                    if (rsp_free)
                    begin
                        if (act_spec_we)
                        begin
                            special_reg <= act_spec;
                        end
                        if (act_out)
                        begin
                            rsp_valid_reg <= 1'b1;
                            rsp_data_reg.status      <= act_status;
                            rsp_data_reg.found_value <= act_value;
                            rsp_data_reg.live_count  <=
                                (act_elem_inc && elem_reg != COUNT_MAX) ?
                                elem_reg + COUNT_W'(1) : elem_reg;
                            rsp_data_reg.tomb_count  <=
                                (act_tomb_inc && tombc_reg != COUNT_MAX) ?
                                tombc_reg + COUNT_W'(1) : tombc_reg;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_VRD;
                        end
                        if (act_elem_inc && elem_reg != COUNT_MAX)
                        begin
                            elem_reg <= elem_reg + COUNT_W'(1);
                        end
                        if (act_tomb_inc && tombc_reg != COUNT_MAX)
                        begin
                            tombc_reg <= tombc_reg + COUNT_W'(1);
                        end
                    end
                end
                S_VRD:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_data_reg.status      <= ST_DONE;
                        rsp_data_reg.found_value <= FIELD_W'(val_rdata);
                        rsp_data_reg.live_count  <= elem_reg;
                        rsp_data_reg.tomb_count  <= tombc_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_writes_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (key_we && key_wdata == KEY_EMPTY))
        else $error("clearing pass does not write an empty key");

    a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> (state_reg == S_IDLE))
        else $error("result raised while an item is still at work");

    a_probe_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> (probe_reg < slots && SW'(p_reg) < slots))
        else $error("probe runs beyond the slot count");
`endif
endmodule
